@@ design/r2fft_pkg.sv @@
package r2fft_pkg;

    localparam int LOG2_MAX_POINTS = 6;
    localparam int ADDR_W          = 6;
    localparam int SAMPLE_W        = 16;
    localparam int DATA_W          = 24;
    localparam int TW_W            = 18;
    localparam int PROD_W          = DATA_W + TW_W;
    localparam int CFG_W           = 3;
    localparam int TW_IDX_W        = 5;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_BF_RD,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_MUL4,
        ST_WR_A,
        ST_WR_B,
        ST_EMIT_RD,
        ST_EMIT_WAIT
    } t_state;

    typedef enum logic [3:0] {
        DP_IDLE,
        DP_LOAD,
        DP_READ,
        DP_MUL0,
        DP_MUL1,
        DP_MUL2,
        DP_MUL3,
        DP_MUL4,
        DP_WR_A,
        DP_WR_B
    } t_dp_op;

    typedef struct packed {
        t_dp_op               op;
        logic                 we;
        logic [ADDR_W-1:0]    addr_a;
        logic [ADDR_W-1:0]    addr_b;
        logic [TW_IDX_W-1:0]  tw_idx;
    } t_dp_cmd;

    typedef struct packed {
        logic signed [TW_W-1:0] c;
        logic signed [TW_W-1:0] s;
    } t_twiddle;

    function automatic logic signed [TW_W-1:0] quarter_cos(input logic [TW_IDX_W-1:0] k);
        logic signed [TW_W-1:0] v;
        case (k)
            5'd0:    v = 18'sd65536;
            5'd1:    v = 18'sd65220;
            5'd2:    v = 18'sd64277;
            5'd3:    v = 18'sd62714;
            5'd4:    v = 18'sd60547;
            5'd5:    v = 18'sd57798;
            5'd6:    v = 18'sd54491;
            5'd7:    v = 18'sd50660;
            5'd8:    v = 18'sd46341;
            5'd9:    v = 18'sd41576;
            5'd10:   v = 18'sd36410;
            5'd11:   v = 18'sd30893;
            5'd12:   v = 18'sd25080;
            5'd13:   v = 18'sd19024;
            5'd14:   v = 18'sd12785;
            5'd15:   v = 18'sd6424;
            default: v = 18'sd0;
        endcase
        return v;
    endfunction

    function automatic t_twiddle twiddle(input logic [TW_IDX_W-1:0] k);
        t_twiddle t;
        logic [5:0] k32;
        k32 = 6'd32 - {1'b0, k};
        if (k <= 5'd16) begin
            t.c = quarter_cos(k);
            t.s = quarter_cos(5'd16 - k);
        end else begin
            t.c = -quarter_cos(k32[TW_IDX_W-1:0]);
            t.s = quarter_cos(k - 5'd16);
        end
        return t;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat25(input logic signed [DATA_W:0] v);
        logic signed [DATA_W-1:0] r;
        if (v[DATA_W] != v[DATA_W-1]) begin
            r = v[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat27(input logic signed [DATA_W+2:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 27'sd8388607) begin
            r = {1'b0, {(DATA_W-1){1'b1}}};
        end else if (v < -27'sd8388608) begin
            r = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ design/r2fft_if.sv @@
interface r2fft_sample_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [r2fft_pkg::SAMPLE_W-1:0]  sample_real;
    logic signed [r2fft_pkg::SAMPLE_W-1:0]  sample_imag;
    modport source (output valid, sample_real, sample_imag, input ready);
    modport sink (input valid, sample_real, sample_imag, output ready);
endinterface

interface r2fft_bin_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [r2fft_pkg::DATA_W-1:0]    bin_real;
    logic signed [r2fft_pkg::DATA_W-1:0]    bin_imag;
    logic [r2fft_pkg::ADDR_W-1:0]           bin_index;
    logic                                   last_bin;
    modport source (output valid, bin_real, bin_imag, bin_index, last_bin, input ready);
    modport sink (input valid, bin_real, bin_imag, bin_index, last_bin, output ready);
endinterface

interface r2fft_cfg_if;
    logic                                   valid;
    logic                                   ready;
    logic [r2fft_pkg::CFG_W-1:0]            log2_points;
    modport source (output valid, log2_points, input ready);
    modport sink (input valid, log2_points, output ready);
endinterface

@@ design/r2fft_dp.sv @@
module r2fft_dp #(
    parameter int LOG2_MAX_POINTS = r2fft_pkg::LOG2_MAX_POINTS
) (
    input  logic                                   i_clk,
    input  r2fft_pkg::t_dp_cmd                     i_cmd,
    input  logic signed [r2fft_pkg::SAMPLE_W-1:0]  i_sample_real,
    input  logic signed [r2fft_pkg::SAMPLE_W-1:0]  i_sample_imag,
    output logic signed [r2fft_pkg::DATA_W-1:0]    o_bin_real,
    output logic signed [r2fft_pkg::DATA_W-1:0]    o_bin_imag
);
    localparam int DEPTH = 1 << LOG2_MAX_POINTS;
    localparam int DW    = r2fft_pkg::DATA_W;
    localparam int PW    = r2fft_pkg::PROD_W;

    logic [2*DW-1:0]        mem [DEPTH];
    logic [2*DW-1:0]        r_rd_a;
    logic [2*DW-1:0]        r_rd_b;
    r2fft_pkg::t_twiddle    r_tw;
    logic signed [PW-1:0]   r_prod;
    logic signed [PW-1:0]   r_acc;
    logic signed [DW-1:0]   r_vr;
    logic signed [DW-1:0]   r_vi;

    logic signed [DW-1:0]   ur, ui, br, bi;
    logic signed [DW-1:0]   mul_a;
    logic signed [r2fft_pkg::TW_W-1:0] mul_b;
    logic signed [PW-1:0]   prod;
    logic signed [PW:0]     sum_re, sum_im;
    logic signed [DW-1:0]   rnd_re, rnd_im;
    logic [2*DW-1:0]        wr_data;
    logic [LOG2_MAX_POINTS-1:0] wr_addr;

    assign ur = r_rd_a[2*DW-1:DW];
    assign ui = r_rd_a[DW-1:0];
    assign br = r_rd_b[2*DW-1:DW];
    assign bi = r_rd_b[DW-1:0];

    always_comb begin
        case (i_cmd.op)
            r2fft_pkg::DP_MUL1: begin
                mul_a = bi;
                mul_b = r_tw.s;
            end
            r2fft_pkg::DP_MUL2: begin
                mul_a = bi;
                mul_b = r_tw.c;
            end
            r2fft_pkg::DP_MUL3: begin
                mul_a = br;
                mul_b = r_tw.s;
            end
            default: begin
                mul_a = br;
                mul_b = r_tw.c;
            end
        endcase
    end

    assign prod   = PW'(mul_a * mul_b);
    assign sum_re = (PW+1)'(r_acc) + (PW+1)'(r_prod) + (PW+1)'(32768);
    assign sum_im = (PW+1)'(r_acc) - (PW+1)'(r_prod) + (PW+1)'(32768);
    assign rnd_re = r2fft_pkg::sat27($signed(sum_re[PW:16]));
    assign rnd_im = r2fft_pkg::sat27($signed(sum_im[PW:16]));

    always_comb begin
        case (i_cmd.op)
            r2fft_pkg::DP_LOAD: begin
                wr_data = {DW'(i_sample_real), DW'(i_sample_imag)};
                wr_addr = i_cmd.addr_a[LOG2_MAX_POINTS-1:0];
            end
            r2fft_pkg::DP_WR_A: begin
                wr_data = {r2fft_pkg::sat25((DW+1)'(ur) + (DW+1)'(r_vr)),
                           r2fft_pkg::sat25((DW+1)'(ui) + (DW+1)'(r_vi))};
                wr_addr = i_cmd.addr_a[LOG2_MAX_POINTS-1:0];
            end
            default: begin
                wr_data = {r2fft_pkg::sat25((DW+1)'(ur) - (DW+1)'(r_vr)),
                           r2fft_pkg::sat25((DW+1)'(ui) - (DW+1)'(r_vi))};
                wr_addr = i_cmd.addr_b[LOG2_MAX_POINTS-1:0];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.op == r2fft_pkg::DP_READ) begin
            r_rd_a <= mem[i_cmd.addr_a[LOG2_MAX_POINTS-1:0]];
            r_rd_b <= mem[i_cmd.addr_b[LOG2_MAX_POINTS-1:0]];
            r_tw   <= r2fft_pkg::twiddle(i_cmd.tw_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            r2fft_pkg::DP_MUL0: begin
                r_prod <= prod;
            end
            r2fft_pkg::DP_MUL1: begin
                r_acc  <= r_prod;
                r_prod <= prod;
            end
            r2fft_pkg::DP_MUL2: begin
                r_vr   <= rnd_re;
                r_prod <= prod;
            end
            r2fft_pkg::DP_MUL3: begin
                r_acc  <= r_prod;
                r_prod <= prod;
            end
            r2fft_pkg::DP_MUL4: begin
                r_vi   <= rnd_im;
            end
            default: begin
            end
        endcase
    end

    assign o_bin_real = ur;
    assign o_bin_imag = ui;

endmodule

@@ design/r2fft_ctrl.sv @@
module r2fft_ctrl #(
    parameter int LOG2_MAX_POINTS = r2fft_pkg::LOG2_MAX_POINTS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [r2fft_pkg::CFG_W-1:0]       i_cfg_log2_points,
    input  logic                              i_sample_valid,
    output logic                              o_sample_ready,
    output logic                              o_bin_valid,
    input  logic                              i_bin_ready,
    output logic [r2fft_pkg::ADDR_W-1:0]      o_bin_index,
    output logic                              o_last_bin,
    output r2fft_pkg::t_dp_cmd                o_cmd
);
    localparam int AW = LOG2_MAX_POINTS;
    localparam logic [r2fft_pkg::CFG_W-1:0] LG_MAX = r2fft_pkg::CFG_W'(LOG2_MAX_POINTS);

    r2fft_pkg::t_state          r_state, n_state;
    logic [r2fft_pkg::CFG_W-1:0] r_lg;
    logic [AW-1:0]              r_count, n_count;
    logic [r2fft_pkg::CFG_W-1:0] r_stage, n_stage;
    logic [AW-1:0]              r_bf, n_bf;
    logic [AW-1:0]              r_k, n_k;

    logic [r2fft_pkg::CFG_W-1:0] lg_eff;
    logic [AW:0]                full_mask;
    logic [AW-1:0]              mask;
    logic [AW-1:0]              half_mask;
    logic [AW:0]                hm_full;
    logic [AW-1:0]              hm;
    logic [AW-1:0]              j_idx;
    logic [AW-1:0]              addr_a, addr_b;
    logic [AW-1:0]              rev_full;
    logic [AW-1:0]              load_addr;
    logic [r2fft_pkg::ADDR_W:0] tw_wide;
    logic                       in_acc;
    logic                       out_acc;

    assign lg_eff    = (r_lg > LG_MAX) ? LG_MAX : r_lg;
    assign full_mask = ((AW+1)'(1) << lg_eff) - (AW+1)'(1);
    assign mask      = full_mask[AW-1:0];
    assign half_mask = mask >> 1;
    assign hm_full   = ((AW+1)'(1) << (r_stage - 3'd1)) - (AW+1)'(1);
    assign hm        = hm_full[AW-1:0];
    assign j_idx     = r_bf & hm;
    assign addr_a    = ((r_bf & ~hm) << 1) | j_idx;
    assign addr_b    = addr_a | (hm + AW'(1));
    assign tw_wide   = (r2fft_pkg::ADDR_W+1)'(j_idx) << (3'd6 - r_stage);

    always_comb begin
        for (int i = 0; i < AW; i++) begin
            rev_full[i] = r_count[AW-1-i];
        end
    end

    assign load_addr = rev_full >> (LG_MAX - lg_eff);
    assign in_acc    = i_sample_valid && o_sample_ready;
    assign out_acc   = o_bin_valid && i_bin_ready;

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_stage = r_stage;
        n_bf    = r_bf;
        n_k     = r_k;
        case (r_state)
            r2fft_pkg::ST_LOAD: begin
                if (in_acc) begin
                    if (r_count == mask) begin
                        n_count = '0;
                        n_stage = 3'd1;
                        n_bf    = '0;
                        n_k     = '0;
                        n_state = (lg_eff == '0) ? r2fft_pkg::ST_EMIT_RD : r2fft_pkg::ST_BF_RD;
                    end else begin
                        n_count = r_count + AW'(1);
                    end
                end
            end
            r2fft_pkg::ST_BF_RD:  n_state = r2fft_pkg::ST_MUL0;
            r2fft_pkg::ST_MUL0:   n_state = r2fft_pkg::ST_MUL1;
            r2fft_pkg::ST_MUL1:   n_state = r2fft_pkg::ST_MUL2;
            r2fft_pkg::ST_MUL2:   n_state = r2fft_pkg::ST_MUL3;
            r2fft_pkg::ST_MUL3:   n_state = r2fft_pkg::ST_MUL4;
            r2fft_pkg::ST_MUL4:   n_state = r2fft_pkg::ST_WR_A;
            r2fft_pkg::ST_WR_A:   n_state = r2fft_pkg::ST_WR_B;
            r2fft_pkg::ST_WR_B: begin
                if (r_bf == half_mask) begin
                    n_bf = '0;
                    if (r_stage == lg_eff) begin
                        n_k     = '0;
                        n_state = r2fft_pkg::ST_EMIT_RD;
                    end else begin
                        n_stage = r_stage + 3'd1;
                        n_state = r2fft_pkg::ST_BF_RD;
                    end
                end else begin
                    n_bf    = r_bf + AW'(1);
                    n_state = r2fft_pkg::ST_BF_RD;
                end
            end
            r2fft_pkg::ST_EMIT_RD: n_state = r2fft_pkg::ST_EMIT_WAIT;
            r2fft_pkg::ST_EMIT_WAIT: begin
                if (out_acc) begin
                    if (r_k == mask) begin
                        n_state = r2fft_pkg::ST_LOAD;
                    end else begin
                        n_k     = r_k + AW'(1);
                        n_state = r2fft_pkg::ST_EMIT_RD;
                    end
                end
            end
            default: n_state = r2fft_pkg::ST_LOAD;
        endcase
        if (i_cfg_valid && o_cfg_ready) begin
            n_count = '0;
        end
    end

    always_comb begin
        o_cmd.op       = r2fft_pkg::DP_IDLE;
        o_cmd.we       = 1'b0;
        o_cmd.addr_a   = r2fft_pkg::ADDR_W'(addr_a);
        o_cmd.addr_b   = r2fft_pkg::ADDR_W'(addr_b);
        o_cmd.tw_idx   = tw_wide[r2fft_pkg::TW_IDX_W-1:0];
        o_sample_ready = 1'b0;
        o_bin_valid    = 1'b0;
        case (r_state)
            r2fft_pkg::ST_LOAD: begin
                o_cmd.op       = r2fft_pkg::DP_LOAD;
                o_cmd.we       = in_acc;
                o_cmd.addr_a   = r2fft_pkg::ADDR_W'(load_addr);
                o_sample_ready = 1'b1;
            end
            r2fft_pkg::ST_BF_RD:  o_cmd.op = r2fft_pkg::DP_READ;
            r2fft_pkg::ST_MUL0:   o_cmd.op = r2fft_pkg::DP_MUL0;
            r2fft_pkg::ST_MUL1:   o_cmd.op = r2fft_pkg::DP_MUL1;
            r2fft_pkg::ST_MUL2:   o_cmd.op = r2fft_pkg::DP_MUL2;
            r2fft_pkg::ST_MUL3:   o_cmd.op = r2fft_pkg::DP_MUL3;
            r2fft_pkg::ST_MUL4:   o_cmd.op = r2fft_pkg::DP_MUL4;
            r2fft_pkg::ST_WR_A: begin
                o_cmd.op = r2fft_pkg::DP_WR_A;
                o_cmd.we = 1'b1;
            end
            r2fft_pkg::ST_WR_B: begin
                o_cmd.op = r2fft_pkg::DP_WR_B;
                o_cmd.we = 1'b1;
            end
            r2fft_pkg::ST_EMIT_RD: begin
                o_cmd.op     = r2fft_pkg::DP_READ;
                o_cmd.addr_a = r2fft_pkg::ADDR_W'(r_k);
            end
            r2fft_pkg::ST_EMIT_WAIT: o_bin_valid = 1'b1;
            default: begin
            end
        endcase
    end

    assign o_cfg_ready = 1'b1;
    assign o_bin_index = r2fft_pkg::ADDR_W'(r_k);
    assign o_last_bin  = (r_k == mask);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= r2fft_pkg::ST_LOAD;
            r_lg    <= r2fft_pkg::CFG_W'(6);
            r_count <= '0;
            r_stage <= 3'd1;
            r_bf    <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_stage <= n_stage;
            r_bf    <= n_bf;
            r_k     <= n_k;
            if (i_cfg_valid && o_cfg_ready) begin
                r_lg <= i_cfg_log2_points;
            end
        end
    end

    a_wr_b_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == r2fft_pkg::ST_WR_B) |=>
        (r_state == r2fft_pkg::ST_BF_RD || r_state == r2fft_pkg::ST_EMIT_RD))
        else $error("butterfly did not advance");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= mask))
        else $error("load count beyond frame length");

    a_stage_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == r2fft_pkg::ST_BF_RD) |-> (r_stage >= 3'd1 && r_stage <= lg_eff))
        else $error("stage out of range");

    a_emit_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == r2fft_pkg::ST_EMIT_WAIT && i_bin_ready) |=>
        (r_state == r2fft_pkg::ST_EMIT_RD || r_state == r2fft_pkg::ST_LOAD))
        else $error("emit did not advance");

endmodule

@@ design/radix2_fft_top.sv @@
// Radix-2 decimation-in-time FFT, forward and unscaled, 2^L points with
// L = min(log2_points, LOG2_MAX_POINTS).
// Channels: i_sample takes one Q15 complex sample per item; o_bin gives
// one 24-bit saturated complex bin per item in natural order, with
// bin_index on every bin and last_bin on the final bin. i_cfg writes
// log2_points and drops any partial frame; the user must see that it is
// written only while the block is idle, which the block does not enforce.
// Samples are stored at bit-reversed addresses, one per cycle. After the
// last sample of a frame, L stages of N/2 butterflies run on one shared
// butterfly unit with one multiplier: a read, five multiply/round steps
// and two write-backs through the single write port. Each bin is then
// fetched by a registered memory read before it is offered, so the next
// bin is read only once the last is taken. Input is not taken during
// compute or emit. When the receiver stalls, the current bin holds on
// o_bin until taken. Reset sets log2_points to 6 and clears the frame;
// store contents are not cleared and need no clearing pass.
module radix2_fft_top #(
    parameter int LOG2_MAX_POINTS = r2fft_pkg::LOG2_MAX_POINTS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    r2fft_cfg_if.sink     i_cfg,
    r2fft_sample_if.sink  i_sample,
    r2fft_bin_if.source   o_bin
);
    r2fft_pkg::t_dp_cmd cmd;

    r2fft_ctrl #(
        .LOG2_MAX_POINTS (LOG2_MAX_POINTS)
    ) u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg.valid),
        .o_cfg_ready       (i_cfg.ready),
        .i_cfg_log2_points (i_cfg.log2_points),
        .i_sample_valid    (i_sample.valid),
        .o_sample_ready    (i_sample.ready),
        .o_bin_valid       (o_bin.valid),
        .i_bin_ready       (o_bin.ready),
        .o_bin_index       (o_bin.bin_index),
        .o_last_bin        (o_bin.last_bin),
        .o_cmd             (cmd)
    );

    r2fft_dp #(
        .LOG2_MAX_POINTS (LOG2_MAX_POINTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_cmd         (cmd),
        .i_sample_real (i_sample.sample_real),
        .i_sample_imag (i_sample.sample_imag),
        .o_bin_real    (o_bin.bin_real),
        .o_bin_imag    (o_bin.bin_imag)
    );

endmodule

@@ bench/fft_checker.sv @@
`timescale 1ns / 1ps

module fft_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    r2fft_cfg_if.sink          i_cfg,
    r2fft_sample_if.sink       i_sample,
    r2fft_bin_if.sink          i_bin,
    output int                 o_fail_count,
    output int                 o_pending
);
    typedef struct packed {
        logic signed [r2fft_pkg::DATA_W-1:0] re;
        logic signed [r2fft_pkg::DATA_W-1:0] im;
        logic [r2fft_pkg::ADDR_W-1:0]        idx;
        logic                                last;
    } t_bin;

    localparam int QCOS [17] = '{65536, 65220, 64277, 62714, 60547, 57798, 54491,
        50660, 46341, 41576, 36410, 30893, 25080, 19024, 12785, 6424, 0};

    t_bin       bin_queue[$];
    longint     frame_re[64];
    longint     frame_im[64];
    logic [2:0] log2_reg;
    int         sample_count;

    function automatic longint clip24(input longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    function automatic longint round_q16(input longint s);
        longint t;
        t = s + 32768;
        return t >>> 16;
    endfunction

    function automatic int reverse_bits(input int v, input int bits);
        int r;
        r = 0;
        for (int i = 0; i < bits; i++) r = (r << 1) | ((v >> i) & 1);
        return r;
    endfunction

    function automatic int active_log2();
        return (log2_reg > r2fft_pkg::LOG2_MAX_POINTS) ? r2fft_pkg::LOG2_MAX_POINTS
                                                       : int'(log2_reg);
    endfunction

    task automatic compute_bins(input int lg);
        int     n, len, half, a, b, k;
        longint c, s, br, bi, ur, ui, vr, vi;
        t_bin   e;
        n = 1 << lg;
        for (int st = 1; st <= lg; st++) begin
            len = 1 << st;
            half = len >> 1;
            for (int base = 0; base < n; base += len) begin
                for (int j = 0; j < half; j++) begin
                    a = base + j;
                    b = a + half;
                    k = (j * (64 >> st)) & 31;
                    if (k <= 16) begin
                        c = QCOS[k];
                        s = QCOS[16 - k];
                    end else begin
                        c = -QCOS[32 - k];
                        s = QCOS[k - 16];
                    end
                    br = frame_re[b]; bi = frame_im[b];
                    ur = frame_re[a]; ui = frame_im[a];
                    vr = clip24(round_q16(br * c + bi * s));
                    vi = clip24(round_q16(bi * c - br * s));
                    frame_re[a] = clip24(ur + vr);
                    frame_im[a] = clip24(ui + vi);
                    frame_re[b] = clip24(ur - vr);
                    frame_im[b] = clip24(ui - vi);
                end
            end
        end
        for (int i = 0; i < n; i++) begin
            e.re = frame_re[i][r2fft_pkg::DATA_W-1:0];
            e.im = frame_im[i][r2fft_pkg::DATA_W-1:0];
            e.idx = i[r2fft_pkg::ADDR_W-1:0];
            e.last = (i == n - 1);
            bin_queue.push_back(e);
        end
    endtask

    assign o_pending = bin_queue.size();

    always @(posedge i_clk) begin
        t_bin got;
        t_bin want;
        int   lg;
        if (!i_rst_n) begin
            log2_reg <= 3'd6;
            sample_count = 0;
            o_fail_count <= 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                log2_reg <= i_cfg.log2_points;
                sample_count = 0;
            end
            if (i_sample.valid && i_sample.ready) begin
                lg = active_log2();
                frame_re[reverse_bits(sample_count, lg)] = i_sample.sample_real;
                frame_im[reverse_bits(sample_count, lg)] = i_sample.sample_imag;
                sample_count++;
                if (sample_count >= (1 << lg)) begin
                    sample_count = 0;
                    compute_bins(lg);
                end
            end
            if (i_bin.valid && i_bin.ready) begin
                got = '{i_bin.bin_real, i_bin.bin_imag, i_bin.bin_index, i_bin.last_bin};
                if (bin_queue.size() == 0) begin
                    $display("%0t: unexpected bin, expected none, actual %h", $time, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = bin_queue.pop_front();
                    if (got !== want) begin
                        $display({"%0t: bin mismatch, expected re %0d im %0d idx %0d",
                                  " last %0d, actual re %0d im %0d idx %0d last %0d"},
                            $time, want.re, want.im, want.idx, want.last,
                            got.re, got.im, got.idx, got.last);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   burst_left = 0;

    r2fft_cfg_if    cfg_ch ();
    r2fft_sample_if sample_ch ();
    r2fft_bin_if    bin_ch ();

    radix2_fft_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg(cfg_ch.sink), .i_sample(sample_ch.sink), .o_bin(bin_ch.source)
    );

    fft_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg(cfg_ch.sink), .i_sample(sample_ch.sink), .i_bin(bin_ch.sink),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        cfg_ch.valid = 1'b0;
        cfg_ch.log2_points = '0;
        sample_ch.valid = 1'b0;
        sample_ch.sample_real = '0;
        sample_ch.sample_imag = '0;
        bin_ch.ready = 1'b0;
    end

    int stall_mode = 0;
    always @(posedge i_clk) begin
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: bin_ch.ready <= 1'b1;
            1: bin_ch.ready <= ($urandom_range(0, 3) != 0);
            2: bin_ch.ready <= ($urandom_range(0, 1) == 0);
            default: bin_ch.ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic write_length(input logic [2:0] value);
        cfg_ch.log2_points <= value;
        cfg_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_sample(input logic signed [15:0] re, input logic signed [15:0] im);
        if (burst_left == 0) begin
            repeat ($urandom_range(0, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        sample_ch.sample_real <= re;
        sample_ch.sample_imag <= im;
        sample_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!sample_ch.ready);
        if (burst_left == 0) sample_ch.valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic drain();
        sample_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic run_frames(input logic [2:0] lg, input int frames);
        int n;
        n = 1 << ((lg > 6) ? 6 : lg);
        write_length(lg);
        for (int f = 0; f < frames; f++)
            for (int i = 0; i < n; i++) send_sample(pick_value(), pick_value());
        drain();
    endtask

    initial begin
        logic [2:0] lg;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_sample(16'sh7fff, 16'sh8000);
        send_sample(16'sh8000, 16'sh7fff);
        for (int i = 0; i < 62; i++) send_sample(16'sh7fff, 16'sh7fff);
        drain();
        write_length(3'd0);
        send_sample(16'sh7fff, 16'sh8000);
        send_sample(16'sh8000, 16'sh0000);
        drain();
        write_length(3'd3);
        for (int i = 0; i < 5; i++) send_sample(16'sh1234, 16'sh4321);
        drain();
        run_frames(3'd3, 1);
        run_frames(3'd7, 1);
        run_frames(3'd0, 6);
        run_frames(3'd1, 8);
        run_frames(3'd2, 6);
        for (int p = 0; p < 5; p++) begin
            lg = 3'($urandom_range(0, 5));
            run_frames(lg, $urandom_range(1, 3));
        end
        run_frames(3'd6, 1);
        if (fail_count == 0) $display("tb_top: PASS");
        else $display("tb_top: FAIL");
        $finish;
    end

    initial begin
        #20ms;
        $display("tb_top: FAIL");
        $finish;
    end
endmodule

@@ files.f @@
design/r2fft_pkg.sv
design/r2fft_if.sv
design/r2fft_dp.sv
design/r2fft_ctrl.sv
design/radix2_fft_top.sv
bench/fft_checker.sv
bench/tb_top.sv
